FILE: hdl/threshold_alarm_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Threshold alarm evaluator assertion macros
// Shorthand for clocked assertions on clk_i with rst_ni as disable.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_ALARM_EVALUATOR_MACROS_SVH
`define THRESHOLD_ALARM_EVALUATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define TAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TAE_ASSERT_IMP(lbl, ante, cons, msg)
`define TAE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/tae_pkg.sv
// ----------------------------------------------------------------------------
// Threshold alarm evaluator package
// Shared types, register map, alarm kinds and state codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tae_pkg;

  // APB address width: eight 32-bit registers
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register map, word index
  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_KIND     = 3'd1,
    REG_MIN_EN   = 3'd2,
    REG_MAX_EN   = 3'd3,
    REG_LOW_THR  = 3'd4,
    REG_HIGH_THR = 3'd5,
    REG_STAY_IVL = 3'd6,
    REG_UPD_IVL  = 3'd7
  } reg_idx_e;

  // alarm kinds; codes above KIND_WINDOW evaluate as inactive
  localparam logic [2:0] KIND_DIG_HIGH = 3'd0;
  localparam logic [2:0] KIND_DIG_LOW  = 3'd1;
  localparam logic [2:0] KIND_BELOW    = 3'd2;
  localparam logic [2:0] KIND_ABOVE    = 3'd3;
  localparam logic [2:0] KIND_WINDOW   = 3'd4;

  // reported state codes
  typedef enum logic [1:0] {
    CODE_OK      = 2'd0,
    CODE_DIGITAL = 2'd1,
    CODE_BELOW   = 2'd2,
    CODE_ABOVE   = 2'd3
  } code_e;

  // configuration register contents
  typedef struct packed {
    logic               enabled;
    logic [2:0]         kind;
    logic               min_en;
    logic               max_en;
    logic signed [31:0] low_thr;
    logic signed [31:0] high_thr;
    logic [31:0]        stay_ivl;
    logic [31:0]        upd_ivl;
  } cfg_t;

  // one input word
  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [31:0] sample;
    logic               digital_level;
    logic               source_valid;
  } item_t;

  // one result word
  typedef struct packed {
    logic       evaluated;
    logic       alarm_active;
    logic [1:0] state_code;
    logic       active_changed;
    logic       entered;
    logic       exited;
    logic       code_changed;
    logic       stay_due;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/threshold_alarm_evaluator.sv
// ----------------------------------------------------------------------------
// Threshold alarm evaluator
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one sample word: timestamp,
//   Q16.16 sample, digital level and source-present flag. Output channel
//   (out_valid_o/out_ready_i) returns exactly one result word per input word,
//   in order. Configuration goes through the APB port (word index = paddr/4)
//   and must be written only while no word is in flight; the block does not enforce this.
//   Path: a word accepted into the input register has its result loaded into
//   the output register once that register is free, and shown from then on.
//   Throughput: one word per cycle unless the output stalls; the alarm state
//   update is a single pass of compare and 32-bit subtract logic between the
//   two registers. Receiver stall: the result holds in the output register;
//   the input register takes one more word if it is empty, then in_ready_o
//   drops until the output drains.
//   Reset: configuration and alarm state registers zero, alarm inactive with
//   code OK, no update time recorded, both stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module threshold_alarm_evaluator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // APB configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tae_pkg::AddrW-1:0]   paddr,
  input  logic [tae_pkg::DataW-1:0]   pwdata,
  output logic [tae_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [31:0]                 now_ms_i,
  input  logic signed [31:0]          sample_i,
  input  logic                        digital_level_i,
  input  logic                        source_valid_i,
  // output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        evaluated_o,
  output logic                        alarm_active_o,
  output logic [1:0]                  state_code_o,
  output logic                        active_changed_o,
  output logic                        entered_o,
  output logic                        exited_o,
  output logic                        code_changed_o,
  output logic                        stay_due_o
);
  import tae_pkg::*;

`include "threshold_alarm_evaluator_macros.svh"

  cfg_t  cfg;
  logic  upd_clr;
  item_t item_q;
  logic  in_valid_q;
  res_t  res, res_q;
  logic  out_valid_q;
  logic  advance;

  // configuration registers
  tae_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .upd_clr_o (upd_clr)
  );

  // word moves from input register to output register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.now_ms        <= now_ms_i;
      item_q.sample        <= sample_i;
      item_q.digital_level <= digital_level_i;
      item_q.source_valid  <= source_valid_i;
    end
  end

  // evaluation and alarm state
  tae_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .upd_clr_i (upd_clr),
    .item_i    (item_q),
    .step_i    (advance),
    .res_o     (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign evaluated_o      = res_q.evaluated;
  assign alarm_active_o   = res_q.alarm_active;
  assign state_code_o     = res_q.state_code;
  assign active_changed_o = res_q.active_changed;
  assign entered_o        = res_q.entered;
  assign exited_o         = res_q.exited;
  assign code_changed_o   = res_q.code_changed;
  assign stay_due_o       = res_q.stay_due;

  // checks
  `TAE_ASSERT_IMP(a_active_matches_code, out_valid_o, alarm_active_o == (state_code_o != CODE_OK), "active flag disagrees with state code")
  `TAE_ASSERT_IMP(a_no_event_unevaluated, out_valid_o && !evaluated_o, !active_changed_o && !entered_o && !exited_o && !code_changed_o && !stay_due_o, "event flag on an unevaluated word")
  `TAE_ASSERT_IMP(a_enter_consistent, out_valid_o && entered_o, alarm_active_o && active_changed_o && !exited_o, "entry flag without active edge")
  `TAE_ASSERT_NXT(a_capture, in_valid_i && in_ready_o, in_valid_q, "accepted word not held in input register")

endmodule

`default_nettype wire

FILE: hdl/tae_regs.sv
// ----------------------------------------------------------------------------
// Threshold alarm evaluator register file
// APB-style configuration registers with zero wait states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tae_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tae_pkg::AddrW-1:0]   paddr,
  input  logic [tae_pkg::DataW-1:0]   pwdata,
  output logic [tae_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output tae_pkg::cfg_t               cfg_o,
  output logic                        upd_clr_o
);
  import tae_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  // write decode
  always_comb begin
    cfg_d     = cfg_q;
    upd_clr_o = 1'b0;
    if (wr_en) begin
      case (idx)
        REG_ENABLE:   cfg_d.enabled  = pwdata[0];
        REG_KIND:     cfg_d.kind     = pwdata[2:0];
        REG_MIN_EN:   cfg_d.min_en   = pwdata[0];
        REG_MAX_EN:   cfg_d.max_en   = pwdata[0];
        REG_LOW_THR:  cfg_d.low_thr  = $signed(pwdata[31:0]);
        REG_HIGH_THR: cfg_d.high_thr = $signed(pwdata[31:0]);
        REG_STAY_IVL: cfg_d.stay_ivl = pwdata[31:0];
        REG_UPD_IVL: begin
          cfg_d.upd_ivl = pwdata[31:0];
          upd_clr_o     = 1'b1;   // also forgets the last update time
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_ENABLE:   prdata[0]    = cfg_q.enabled;
      REG_KIND:     prdata[2:0]  = cfg_q.kind;
      REG_MIN_EN:   prdata[0]    = cfg_q.min_en;
      REG_MAX_EN:   prdata[0]    = cfg_q.max_en;
      REG_LOW_THR:  prdata[31:0] = cfg_q.low_thr;
      REG_HIGH_THR: prdata[31:0] = cfg_q.high_thr;
      REG_STAY_IVL: prdata[31:0] = cfg_q.stay_ivl;
      REG_UPD_IVL:  prdata[31:0] = cfg_q.upd_ivl;
      default:      prdata       = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/tae_core.sv
// ----------------------------------------------------------------------------
// Threshold alarm evaluator core
// Rate gate, level/window comparison, alarm state and edge/stay events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tae_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tae_pkg::cfg_t  cfg_i,
  input  logic           upd_clr_i,   // update interval written
  input  tae_pkg::item_t item_i,
  input  logic           step_i,      // commit state for item_i
  output tae_pkg::res_t  res_o
);
  import tae_pkg::*;

  logic [31:0] last_upd_q;
  logic        upd_vld_q;
  logic        act_q;
  code_e       code_q;
  logic [31:0] last_stay_q;

  logic [31:0] upd_diff, stay_base, stay_diff;
  logic        go, kind_known, is_digital, below, above;
  logic        evaluated, nxt_act, entering, stay_due;
  code_e       nxt_code;

  // update interval gate
  assign upd_diff = item_i.now_ms - last_upd_q;
  assign go = !((cfg_i.upd_ivl != '0) && upd_vld_q && (upd_diff < cfg_i.upd_ivl));

  assign kind_known = (cfg_i.kind <= KIND_WINDOW);
  assign is_digital = (cfg_i.kind <= KIND_DIG_LOW);
  assign below = cfg_i.min_en && ($signed(item_i.sample) < $signed(cfg_i.low_thr));
  assign above = cfg_i.max_en && ($signed(item_i.sample) > $signed(cfg_i.high_thr));

  // missing source skips evaluation only for known kinds of an enabled alarm
  assign evaluated = go && !(cfg_i.enabled && kind_known && !item_i.source_valid);

  // next alarm state
  always_comb begin
    nxt_act  = 1'b0;
    nxt_code = CODE_OK;
    if (cfg_i.enabled && kind_known) begin
      if (is_digital) begin
        nxt_act = (item_i.digital_level == (cfg_i.kind == KIND_DIG_HIGH));
        if (nxt_act) begin
          nxt_code = CODE_DIGITAL;
        end
      end else if (cfg_i.kind == KIND_BELOW) begin
        if (below) begin
          nxt_act  = 1'b1;
          nxt_code = CODE_BELOW;
        end
      end else if (cfg_i.kind == KIND_ABOVE) begin
        if (above) begin
          nxt_act  = 1'b1;
          nxt_code = CODE_ABOVE;
        end
      end else begin
        // window: minimum wins
        if (below) begin
          nxt_act  = 1'b1;
          nxt_code = CODE_BELOW;
        end else if (above) begin
          nxt_act  = 1'b1;
          nxt_code = CODE_ABOVE;
        end
      end
    end
  end

  // stay repeat, restarted on entry
  assign entering  = evaluated && nxt_act && !act_q;
  assign stay_base = entering ? item_i.now_ms : last_stay_q;
  assign stay_diff = item_i.now_ms - stay_base;
  assign stay_due  = evaluated && nxt_act && (cfg_i.stay_ivl != '0) &&
                     (stay_diff >= cfg_i.stay_ivl);

  // result word
  always_comb begin
    res_o.evaluated      = evaluated;
    res_o.alarm_active   = evaluated ? nxt_act : act_q;
    res_o.state_code     = evaluated ? nxt_code : code_q;
    res_o.active_changed = evaluated && (nxt_act != act_q);
    res_o.entered        = entering;
    res_o.exited         = evaluated && !nxt_act && act_q;
    res_o.code_changed   = evaluated && (nxt_code != code_q);
    res_o.stay_due       = stay_due;
  end

  // alarm state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_upd_q  <= '0;
      upd_vld_q   <= 1'b0;
      act_q       <= 1'b0;
      code_q      <= CODE_OK;
      last_stay_q <= '0;
    end else if (upd_clr_i) begin
      last_upd_q <= '0;
      upd_vld_q  <= 1'b0;
    end else if (step_i) begin
      if (go) begin
        last_upd_q <= item_i.now_ms;
        upd_vld_q  <= 1'b1;
      end
      if (evaluated) begin
        act_q  <= nxt_act;
        code_q <= nxt_code;
      end
      if (entering || stay_due) begin
        last_stay_q <= item_i.now_ms;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Threshold alarm evaluator testbench
// Drives sample words through the valid/ready input channel and checks every
// result word against a predicted or pinned word. A directed table covers
// disabled alarms, each alarm kind, missing sources, update-interval gating
// and stay repeats; random segments then re-program all registers over APB
// and stream sticky sensor traces under rotating idle and stall patterns.
// ----------------------------------------------------------------------------

module tb;
  import tae_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandSegments  = 8;
  localparam int unsigned SegWords      = 180;

  // kind codes past the window kind evaluate as inactive
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  // one line of the directed table: a register write or a sample word
  typedef struct {
    row_kind_e kind;
    reg_idx_e  idx;
    logic [31:0] val;
    item_t     w;
    bit        pinned;
    res_t      want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;
  logic in_valid_i, in_ready_o;
  logic [31:0] now_ms_i;
  logic signed [31:0] sample_i;
  logic digital_level_i, source_valid_i;
  logic out_valid_o, out_ready_i;
  logic evaluated_o, alarm_active_o;
  logic [1:0] state_code_o;
  logic active_changed_o, entered_o, exited_o, code_changed_o, stay_due_o;

  // typed-in expectation that rides along with the word being offered
  logic pin_en;
  res_t pin_res;

  threshold_alarm_evaluator dut (.*);

  // 4 ns clock
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor copy of the registers and alarm state
  cfg_t        alarm_cfg;
  logic [31:0] upd_time;
  logic        upd_seen;
  logic        act_flag;
  code_e       cur_code;
  logic [31:0] stay_time;

  res_t pending_alarm_q[$];
  row_t dir_rows[$];

  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned n_errors, n_words, n_results, n_eval, n_enter, n_stay, n_cfg;
  int unsigned quiet_cycles;

  // next alarm result for one accepted word; advances the predictor state
  function automatic res_t predict_alarm(item_t w);
    res_t  r;
    logic  nxt_act;
    code_e nxt_code;
    logic  go, eval, below, above;
    r        = '0;
    nxt_act  = 1'b0;
    nxt_code = CODE_OK;
    go = !(alarm_cfg.upd_ivl != 0 && upd_seen && (w.now_ms - upd_time) < alarm_cfg.upd_ivl);
    eval = go;
    if (go) begin
      upd_time = w.now_ms;
      upd_seen = 1'b1;
      if (alarm_cfg.enabled && alarm_cfg.kind <= KIND_WINDOW) begin
        below = alarm_cfg.min_en && ($signed(w.sample) < $signed(alarm_cfg.low_thr));
        above = alarm_cfg.max_en && ($signed(w.sample) > $signed(alarm_cfg.high_thr));
        if (!w.source_valid) begin
          eval = 1'b0;
        end else if (alarm_cfg.kind == KIND_DIG_HIGH || alarm_cfg.kind == KIND_DIG_LOW) begin
          nxt_act  = (w.digital_level == (alarm_cfg.kind == KIND_DIG_HIGH));
          nxt_code = nxt_act ? CODE_DIGITAL : CODE_OK;
        end else if (below && alarm_cfg.kind != KIND_ABOVE) begin
          // window kind tests the minimum first
          nxt_act  = 1'b1;
          nxt_code = CODE_BELOW;
        end else if (above && alarm_cfg.kind != KIND_BELOW) begin
          nxt_act  = 1'b1;
          nxt_code = CODE_ABOVE;
        end
      end
    end
    if (eval) begin
      if (nxt_act != act_flag) begin
        r.active_changed = 1'b1;
        r.entered        = nxt_act;
        r.exited         = !nxt_act;
        act_flag         = nxt_act;
        if (nxt_act) stay_time = w.now_ms;
      end
      if (nxt_code != cur_code) begin
        r.code_changed = 1'b1;
        cur_code       = nxt_code;
      end
      if (act_flag && alarm_cfg.stay_ivl != 0 &&
          (w.now_ms - stay_time) >= alarm_cfg.stay_ivl) begin
        stay_time  = w.now_ms;
        r.stay_due = 1'b1;
      end
    end
    r.evaluated    = eval;
    r.alarm_active = act_flag;
    r.state_code   = cur_code;
    return r;
  endfunction

  function automatic res_t exp_of(bit ev, bit act, code_e c, bit chg, bit ent, bit ext,
                                  bit cc, bit sd);
    return {ev, act, c, chg, ent, ext, cc, sd};
  endfunction

  function automatic void add_cfg(reg_idx_e idx, logic [31:0] v);
    row_t r;
    r.kind   = ROW_CFG;
    r.idx    = idx;
    r.val    = v;
    r.w      = '0;
    r.pinned = 1'b0;
    r.want   = '0;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void add_word(logic [31:0] now, logic [31:0] smp, bit lvl, bit vld,
                                   bit pinned, res_t want);
    row_t r;
    r.kind   = ROW_WORD;
    r.idx    = REG_ENABLE;
    r.val    = '0;
    r.w      = {now, smp, lvl, vld};
    r.pinned = pinned;
    r.want   = want;
    dir_rows = {dir_rows, r};
  endfunction

  // threshold: mostly small values, some extremes and full-range values
  function automatic logic [31:0] pick_thr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
    if (r < 85) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom();
  endfunction

  // sample: mostly at or next to a limit so both sides of it are hit
  function automatic logic [31:0] pick_sample();
    int unsigned r;
    logic [31:0] thr;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      thr = $urandom_range(0, 1) ? alarm_cfg.low_thr : alarm_cfg.high_thr;
      return thr + $urandom_range(0, 6) - 3;
    end
    if (r < 75) return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
    if (r < 87) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  function automatic void set_idle_mode(int unsigned m);
    send_idle_pct  = (m == 1) ? 46 : (m == 3) ? 20 : 0;
    recv_stall_pct = (m == 2) ? 46 : (m == 3) ? 20 : 0;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  // APB write: setup, access, then release
  task automatic cfg_write(reg_idx_e idx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:   alarm_cfg.enabled  = v[0];
      REG_KIND:     alarm_cfg.kind     = v[2:0];
      REG_MIN_EN:   alarm_cfg.min_en   = v[0];
      REG_MAX_EN:   alarm_cfg.max_en   = v[0];
      REG_LOW_THR:  alarm_cfg.low_thr  = v;
      REG_HIGH_THR: alarm_cfg.high_thr = v;
      REG_STAY_IVL: alarm_cfg.stay_ivl = v;
      REG_UPD_IVL: begin
        // interval write forgets the last update time
        alarm_cfg.upd_ivl = v;
        upd_seen          = 1'b0;
        upd_time          = '0;
      end
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    n_cfg++;
  endtask

  // offer one word, with optional idle cycles first; returns at acceptance
  task automatic send_word(item_t w, bit pinned, res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {now_ms_i, sample_i, digital_level_i, source_valid_i} <= w;
    pin_en  <= pinned;
    pin_res <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // block idle: nothing offered and every result returned
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_alarm_q.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // predict on input handshake, compare on output handshake
  always @(posedge clk_i) begin
    item_t w;
    res_t  pred, got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        w    = {now_ms_i, sample_i, digital_level_i, source_valid_i};
        pred = predict_alarm(w);
        pending_alarm_q = {pending_alarm_q, (pin_en ? pin_res : pred)};
        n_words++;
      end
      if (out_valid_o && out_ready_i) begin
        got = {evaluated_o, alarm_active_o, state_code_o, active_changed_o, entered_o,
               exited_o, code_changed_o, stay_due_o};
        n_results++;
        if (evaluated_o) n_eval++;
        if (entered_o) n_enter++;
        if (stay_due_o) n_stay++;
        if (pending_alarm_q.size() == 0) begin
          $display("%0t ns: result word with nothing pending: expected none, got %h",
                   $time, got);
          n_errors++;
        end else begin
          want = pending_alarm_q.pop_front();
          check_field("evaluated", want.evaluated, got.evaluated);
          check_field("alarm_active", want.alarm_active, got.alarm_active);
          check_field("state_code", want.state_code, got.state_code);
          check_field("active_changed", want.active_changed, got.active_changed);
          check_field("entered", want.entered, got.entered);
          check_field("exited", want.exited, got.exited);
          check_field("code_changed", want.code_changed, got.code_changed);
          check_field("stay_due", want.stay_due, got.stay_due);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results pending", $time,
               WatchdogLimit, pending_alarm_q.size());
      $display("** threshold_alarm_evaluator: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] now_cur, smp;
    logic        lvl, vld;
    int unsigned r;
    item_t       w;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    now_ms_i        = '0;
    sample_i        = '0;
    digital_level_i = 1'b0;
    source_valid_i  = 1'b0;
    out_ready_i     = 1'b0;
    pin_en          = 1'b0;
    pin_res         = '0;
    quiet_cycles    = 0;
    n_errors = 0; n_words = 0; n_results = 0; n_eval = 0;
    n_enter = 0; n_stay = 0; n_cfg = 0;
    alarm_cfg = '0;
    upd_time  = '0;
    upd_seen  = 1'b0;
    act_flag  = 1'b0;
    cur_code  = CODE_OK;
    stay_time = '0;
    set_idle_mode(0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled after reset: evaluated, inactive, even without a source
    add_word(32'h0000_0000, 32'h0000_0000, 0, 1, 1, exp_of(1, 0, CODE_OK, 0, 0, 0, 0, 0));
    add_word(32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 0, 1, exp_of(1, 0, CODE_OK, 0, 0, 0, 0, 0));
    // digital high active, stay every 3 ms
    add_cfg(REG_ENABLE, 1);
    add_cfg(REG_KIND, 32'(KIND_DIG_HIGH));
    add_cfg(REG_STAY_IVL, 3);
    add_word(32'd10, 32'h8000_0000, 1, 1, 1, exp_of(1, 1, CODE_DIGITAL, 1, 1, 0, 1, 0));
    add_word(32'd12, 32'h0, 1, 1, 0, '0);
    add_word(32'd13, 32'h0, 1, 1, 0, '0);
    // source missing holds the state
    add_word(32'd14, 32'h0, 1, 0, 1, exp_of(0, 1, CODE_DIGITAL, 0, 0, 0, 0, 0));
    add_word(32'd20, 32'h0, 0, 1, 0, '0);
    add_cfg(REG_KIND, 32'(KIND_DIG_LOW));
    add_word(32'd21, 32'h0, 0, 1, 0, '0);
    add_word(32'd22, 32'h0, 1, 1, 0, '0);
    // analog kinds, limits at -5.0 and +5.0, equality is not a violation
    add_cfg(REG_KIND, 32'(KIND_BELOW));
    add_cfg(REG_MIN_EN, 1);
    add_cfg(REG_MAX_EN, 1);
    add_cfg(REG_LOW_THR, 32'hFFFB_0000);
    add_cfg(REG_HIGH_THR, 32'h0005_0000);
    add_cfg(REG_STAY_IVL, 0);
    add_word(32'd30, 32'h8000_0000, 0, 1, 0, '0);
    add_word(32'd31, 32'hFFFB_0000, 0, 1, 0, '0);
    add_cfg(REG_KIND, 32'(KIND_ABOVE));
    add_word(32'd32, 32'h7FFF_FFFF, 0, 1, 0, '0);
    add_word(32'd33, 32'h0005_0000, 0, 1, 0, '0);
    add_cfg(REG_KIND, 32'(KIND_WINDOW));
    add_word(32'd34, 32'h8000_0000, 0, 1, 0, '0);
    add_word(32'd35, 32'h7FFF_FFFF, 0, 1, 0, '0);
    add_word(32'd36, 32'h0, 0, 1, 0, '0);
    add_cfg(REG_MIN_EN, 0);
    add_word(32'd37, 32'h8000_0000, 0, 1, 0, '0);
    // crossed limits: both tests hit, minimum wins
    add_cfg(REG_MIN_EN, 1);
    add_cfg(REG_LOW_THR, 32'h7FFF_FFFF);
    add_cfg(REG_HIGH_THR, 32'h8000_0000);
    add_word(32'd38, 32'h0, 0, 1, 0, '0);
    // unused kinds evaluate as inactive, source flag ignored
    add_cfg(REG_KIND, 32'(KIND_UNUSED_LO));
    add_word(32'd39, 32'h0, 0, 1, 0, '0);
    add_cfg(REG_KIND, 32'(KIND_UNUSED_HI));
    add_word(32'd40, 32'h0, 0, 0, 1, exp_of(1, 0, CODE_OK, 0, 0, 0, 0, 0));
    // update gating across the timestamp wrap
    add_cfg(REG_KIND, 32'(KIND_DIG_HIGH));
    add_cfg(REG_UPD_IVL, 100);
    add_word(32'hFFFF_FFF0, 32'h0, 1, 1, 0, '0);
    add_word(32'h0000_0050, 32'h0, 1, 1, 1, exp_of(0, 1, CODE_DIGITAL, 0, 0, 0, 0, 0));
    add_word(32'h0000_0054, 32'h0, 0, 1, 0, '0);
    // largest intervals: due only one full wrap later
    add_cfg(REG_UPD_IVL, 32'hFFFF_FFFF);
    add_cfg(REG_STAY_IVL, 32'hFFFF_FFFF);
    add_word(32'd5, 32'h0, 1, 1, 0, '0);
    add_word(32'd4, 32'h0, 1, 1, 0, '0);
    // disabling forces the alarm off
    add_cfg(REG_ENABLE, 0);
    add_cfg(REG_UPD_IVL, 0);
    add_word(32'd6, 32'h0, 1, 1, 0, '0);

    set_idle_mode(3);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].pinned, dir_rows[i].want);
      end
    end

    // random segments, each with a fresh register set
    for (int unsigned seg = 0; seg < RandSegments; seg++) begin
      wait_drain();
      set_idle_mode(seg % 4);
      cfg_write(REG_ENABLE, 32'($urandom_range(0, 99) < 85));
      r = $urandom_range(0, 99);
      cfg_write(REG_KIND, (r < 90) ? $urandom_range(KIND_DIG_HIGH, KIND_WINDOW)
                                   : $urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      cfg_write(REG_MIN_EN, 32'($urandom_range(0, 3) != 0));
      cfg_write(REG_MAX_EN, 32'($urandom_range(0, 3) != 0));
      cfg_write(REG_LOW_THR, pick_thr());
      cfg_write(REG_HIGH_THR, pick_thr());
      r = $urandom_range(0, 99);
      cfg_write(REG_STAY_IVL, (r < 25) ? 32'd0 : (r < 85) ? $urandom_range(1, 50) :
                              (r < 93) ? $urandom() : 32'hFFFF_FFFF);
      r = $urandom_range(0, 99);
      cfg_write(REG_UPD_IVL, (r < 50) ? 32'd0 : (r < 88) ? $urandom_range(1, 40) :
                             (r < 95) ? $urandom_range(41, 2000) : 32'hFFFF_FFFF);

      case ($urandom_range(0, 3))
        0: now_cur = 32'h0;
        1: now_cur = 32'hFFFF_FF00 + $urandom_range(0, 255);
        default: now_cur = $urandom();
      endcase
      lvl = 1'($urandom_range(0, 1));
      smp = pick_sample();
      for (int unsigned k = 0; k < SegWords; k++) begin
        // mostly small time steps, with some jumps
        r = $urandom_range(0, 99);
        if (r < 85) now_cur = now_cur + $urandom_range(0, 30);
        else if (r < 95) now_cur = now_cur + $urandom_range(31, 400);
        else now_cur = $urandom();
        // sticky level and sample give long active runs
        if ($urandom_range(0, 99) < 20) lvl = !lvl;
        if ($urandom_range(0, 99) >= 65) smp = pick_sample();
        vld = ($urandom_range(0, 99) < 90);
        w = {now_cur, smp, lvl, vld};
        send_word(w, 1'b0, '0);
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (pending_alarm_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_alarm_q.size());
      n_errors++;
    end

    $display("Run: %0d words, %0d results, %0d register writes, %0d mismatches",
             n_words, n_results, n_cfg, n_errors);
    $display("Seen: %0d evaluated, %0d alarm entries, %0d stay repeats, all idle modes",
             n_eval, n_enter, n_stay);
    if (n_errors == 0) begin
      $display("** threshold_alarm_evaluator: PASSED **");
    end else begin
      $display("** threshold_alarm_evaluator: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/tae_pkg.sv
hdl/tae_regs.sv
hdl/tae_core.sv
hdl/threshold_alarm_evaluator.sv
tb/tb.sv
